// ===== design/ftdt_pkg.sv =====
// Shared constants for the fixed-point to decimal text converter.
`timescale 1ns / 1ps
package ftdt_pkg;

	// Integer part after saturation fits 31 bits (max 2147483647, ten digits).
	localparam int INT_W   = 31;
	localparam int NUM_DIG = 10;
	localparam int BCD_W   = 4 * NUM_DIG;
	localparam int CNT_W   = $clog2(INT_W + 1);
	localparam int DIG_IW  = $clog2(NUM_DIG);

	localparam logic [63:0] INT_SAT = 64'd2147483647;

	localparam logic [6:0] CH_MINUS = 7'd45;
	localparam logic [6:0] CH_POINT = 7'd46;
	localparam logic [6:0] CH_ZERO  = 7'd48;

	localparam logic [63:0] POW10 [0:11] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
		64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000,
		64'd10000000000, 64'd100000000000
	};

endpackage

// ===== design/ftdt_bcd.sv =====
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps
module ftdt_bcd
	import ftdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [INT_W-1:0]  bin,
	output logic              done,
	output logic [BCD_W-1:0]  digits
);

	logic [INT_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= CNT_W'(INT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[INT_W-1]};
			bin_q <= {bin_q[INT_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

// ===== design/ftdt_frac.sv =====
// Fraction digit generator: multiplies the fraction by ten once per step.
`timescale 1ns / 1ps
module ftdt_frac #(
	parameter int FRAC_BITS = 32
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic [FRAC_BITS-1:0] frac_in,
	input  logic                 step,
	output logic [3:0]           digit
);

	logic [FRAC_BITS-1:0] frac_q;
	logic [FRAC_BITS+3:0] ext;
	logic [FRAC_BITS+3:0] prod;

	assign ext   = {4'b0000, frac_q};
	assign prod  = (ext << 3) + (ext << 1);
	assign digit = prod[FRAC_BITS+3:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (load) begin
			frac_q <= frac_in;
		end else if (step) begin
			frac_q <= prod[FRAC_BITS-1:0];
		end
	end

endmodule

// ===== design/fixed_to_decimal_text_core.sv =====
// Top level: fixed-point to decimal text converter, one character per strobe.
// Sequence: an accepted item passes through precision select, rounding and the
//   31-step BCD converter before the first character, then one character per cycle (up to 22).
// A new item is taken only after the last character; busy holds meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous) returns to idle with no strobe pending.
`timescale 1ns / 1ps
module fixed_to_decimal_text_core
	import ftdt_pkg::*;
#(
	parameter int FRAC_BITS       = 32,
	parameter int PRECISION_LIMIT = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [63:0] value,
	input  logic signed [4:0] precision,
	output logic              busy,
	output logic              strobe,
	output logic [6:0]        char_code,
	output logic              last
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREC  = 8'b0000_0010,
		S_ROUND = 8'b0000_0100,
		S_CONV  = 8'b0000_1000,
		S_SIGN  = 8'b0001_0000,
		S_INT   = 8'b0010_0000,
		S_POINT = 8'b0100_0000,
		S_FRAC  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [63:0]          mag_q;
	logic                 neg_q;
	logic [4:0]           prec_in_q;
	logic [3:0]           prec_q;
	logic [3:0]           frac_cnt_q;
	logic [DIG_IW-1:0]    dig_idx_q;
	logic                 strobe_q;
	logic [6:0]           char_q;
	logic                 last_q;

	logic [63:0]          round_tab [0:15];
	logic [63:0]          ip_pre;
	logic [3:0]           auto_prec;
	logic [3:0]           prec_next;
	logic [63:0]          rounded;
	logic [63:0]          ip_post;
	logic [INT_W-1:0]     ip_sat;
	logic [FRAC_BITS-1:0] frac_sat;
	logic                 bcd_load;
	logic                 bcd_done;
	logic [BCD_W-1:0]     bcd_digits;
	logic [DIG_IW-1:0]    lead_idx;
	logic                 frac_load;
	logic                 frac_step;
	logic [3:0]           frac_digit;
	logic [3:0]           int_digit;

	// Rounding constant 0.5*10^-p on the fraction grid, rounded to nearest.
	for (genvar gi = 0; gi < 16; gi++) begin : g_round
		if (gi <= 10) begin : g_used
			localparam logic [63:0] P = POW10[gi+1];
			localparam logic [63:0] RC = ((64'd5 << FRAC_BITS) + P / 2) / P;
			assign round_tab[gi] = RC;
		end else begin : g_unused
			assign round_tab[gi] = '0;
		end
	end

	assign ip_pre = mag_q >> FRAC_BITS;

	always_comb begin
		auto_prec = 4'd0;
		for (int k = 5; k >= 0; k--) begin
			if (ip_pre < POW10[k]) begin
				auto_prec = 4'(6 - k);
			end
		end
		if (prec_in_q[4]) begin
			prec_next = (auto_prec > 4'(PRECISION_LIMIT)) ? 4'(PRECISION_LIMIT) : auto_prec;
		end else if (prec_in_q > 5'(PRECISION_LIMIT)) begin
			prec_next = 4'(PRECISION_LIMIT);
		end else begin
			prec_next = prec_in_q[3:0];
		end
	end

	// Add rounding and saturate the integer part.
	assign rounded = mag_q + ((prec_q != 4'd0) ? round_tab[prec_q] : 64'd0);
	assign ip_post = rounded >> FRAC_BITS;

	always_comb begin
		if (ip_post > INT_SAT) begin
			ip_sat   = INT_SAT[INT_W-1:0];
			frac_sat = '1;
		end else begin
			ip_sat   = ip_post[INT_W-1:0];
			frac_sat = rounded[FRAC_BITS-1:0];
		end
	end

	assign bcd_load  = (state_q == S_ROUND);
	assign frac_load = (state_q == S_ROUND);
	assign frac_step = (state_q == S_FRAC);

	ftdt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (bcd_load),
		.bin    (ip_sat),
		.done   (bcd_done),
		.digits (bcd_digits)
	);

	ftdt_frac #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac (
		.clk     (clk),
		.load    (frac_load),
		.frac_in (frac_sat),
		.step    (frac_step),
		.digit   (frac_digit)
	);

	// Highest nonzero digit; a zero integer part still shows one '0'.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (bcd_digits[4*i +: 4] != 4'd0) begin
				lead_idx = DIG_IW'(i);
			end
		end
	end

	assign int_digit = bcd_digits[4*dig_idx_q +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREC;
					end
				end
				S_PREC:  state_q <= S_ROUND;
				S_ROUND: state_q <= S_CONV;
				S_CONV: begin
					if (bcd_done) begin
						state_q <= neg_q ? S_SIGN : S_INT;
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= S_INT;
				end
				S_INT: begin
					strobe_q <= 1'b1;
					if (dig_idx_q == '0) begin
						state_q <= (prec_q == 4'd0) ? S_IDLE : S_POINT;
					end
				end
				S_POINT: begin
					strobe_q <= 1'b1;
					state_q  <= S_FRAC;
				end
				S_FRAC: begin
					strobe_q <= 1'b1;
					if (frac_cnt_q == 4'd1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					neg_q     <= value[63];
					mag_q     <= value[63] ? (~value + 64'd1) : value;
					prec_in_q <= precision;
				end
			end
			S_PREC: begin
				prec_q <= prec_next;
			end
			S_CONV: begin
				dig_idx_q  <= lead_idx;
				frac_cnt_q <= prec_q;
			end
			S_SIGN: begin
				char_q <= CH_MINUS;
				last_q <= 1'b0;
			end
			S_INT: begin
				char_q <= CH_ZERO + {3'b000, int_digit};
				last_q <= (dig_idx_q == '0) && (prec_q == 4'd0);
				if (dig_idx_q != '0) begin
					dig_idx_q <= dig_idx_q - 1'b1;
				end
			end
			S_POINT: begin
				char_q <= CH_POINT;
				last_q <= 1'b0;
			end
			S_FRAC: begin
				char_q     <= CH_ZERO + {3'b000, frac_digit};
				last_q     <= (frac_cnt_q == 4'd1);
				frac_cnt_q <= frac_cnt_q - 1'b1;
			end
			default: begin
				// hold
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

// ===== dv/fixed_to_decimal_text_checker.sv =====
// Checker for the decimal text converter: predicts the characters of each item and compares.
`timescale 1ns / 1ps
module fixed_to_decimal_text_checker
	import ftdt_pkg::*;
#(
	parameter int FRAC_BITS       = 32,
	parameter int PRECISION_LIMIT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [63:0] value,
	input  logic signed [4:0]  precision,
	input  logic               strobe,
	input  logic [6:0]         char_code,
	input  logic               last,
	output int                 mismatch_count,
	output int                 chars_pending
);

	typedef struct packed {
		logic [6:0] code;
		logic       fin;
	} text_char_t;

	text_char_t expected_text [$];
	int         item_count;

	initial begin
		mismatch_count = 0;
		chars_pending  = 0;
		item_count     = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Queue the characters that one number turns into.
	task automatic predict_text(input logic [63:0] raw, input logic signed [4:0] pw);
		logic [63:0] one_q;
		logic [63:0] mask;
		logic [63:0] mag;
		logic [63:0] ip;
		logic [63:0] frac;
		logic [63:0] scale;
		logic [63:0] half_step;
		logic [63:0] digit;
		logic [3:0]  digs [0:9];
		logic [6:0]  text [$];
		text_char_t  c;
		int          p;
		int          cnt;
		int          i;
		one_q = 64'd1 << FRAC_BITS;
		mask  = one_q - 64'd1;
		mag   = raw[63] ? (~raw + 64'd1) : raw;
		p     = int'(pw);
		if (p > PRECISION_LIMIT)
			p = PRECISION_LIMIT;
		if (raw[63])
			text.push_back(CH_MINUS);
		// automatic precision from the integer part before rounding
		if (p < 0) begin
			ip = mag >> FRAC_BITS;
			if (ip < 64'd1)           p = 6;
			else if (ip < 64'd10)     p = 5;
			else if (ip < 64'd100)    p = 4;
			else if (ip < 64'd1000)   p = 3;
			else if (ip < 64'd10000)  p = 2;
			else if (ip < 64'd100000) p = 1;
			else                      p = 0;
			if (p > PRECISION_LIMIT)
				p = PRECISION_LIMIT;
		end
		if (p > 0) begin
			scale = 64'd1;
			for (i = 0; i <= p; i++)
				scale = scale * 64'd10;
			half_step = ((64'd5 << FRAC_BITS) + (scale >> 1)) / scale;
			mag = mag + half_step;
		end
		ip   = mag >> FRAC_BITS;
		frac = mag & mask;
		if (ip > INT_SAT) begin
			ip   = INT_SAT;
			frac = mask;
		end
		if (ip == 64'd0) begin
			text.push_back(CH_ZERO);
		end else begin
			cnt = 0;
			while (ip != 64'd0 && cnt < 10) begin
				digit     = ip % 64'd10;
				digs[cnt] = digit[3:0];
				ip        = ip / 64'd10;
				cnt++;
			end
			for (i = cnt - 1; i >= 0; i--)
				text.push_back(CH_ZERO + {3'b000, digs[i]});
		end
		if (p > 0) begin
			text.push_back(CH_POINT);
			for (i = 0; i < p; i++) begin
				frac  = frac * 64'd10;
				digit = frac >> FRAC_BITS;
				text.push_back(CH_ZERO + {3'b000, digit[3:0]});
				frac  = frac & mask;
			end
		end
		for (i = 0; i < text.size(); i++) begin
			c.code = text[i];
			c.fin  = (i == text.size() - 1);
			expected_text.push_back(c);
		end
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_text(value, precision);
				item_count++;
			end
			if (strobe) begin
				if (expected_text.size() == 0) begin
					flag_mismatch($sformatf("character 0x%02h with nothing expected", char_code));
				end else begin
					want = expected_text.pop_front();
					if (char_code !== want.code)
						flag_mismatch($sformatf("char_code 0x%02h, want 0x%02h (item %0d)",
							char_code, want.code, item_count));
					if (last !== want.fin)
						flag_mismatch($sformatf("last %b, want %b (item %0d)",
							last, want.fin, item_count));
				end
			end
			chars_pending = expected_text.size();
		end
	end

endmodule

// ===== dv/tb_fixed_to_decimal_text_core.sv =====
// Testbench top: drives numbers into the decimal text converter and reports the verdict.
`timescale 1ns / 1ps
module tb_fixed_to_decimal_text_core;
	import ftdt_pkg::*;

	localparam int FRAC_BITS       = 32;
	localparam int PRECISION_LIMIT = 10;
	localparam int RAND_ITEMS      = 360;
	localparam int CALM_TAIL       = 60;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [63:0] value;
	logic signed [4:0]  precision;
	logic               busy;
	logic               strobe;
	logic [6:0]         char_code;
	logic               last;
	int                 mismatch_count;
	int                 chars_pending;

	fixed_to_decimal_text_core #(
		.FRAC_BITS(FRAC_BITS),
		.PRECISION_LIMIT(PRECISION_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.value(value),
		.precision(precision),
		.busy(busy),
		.strobe(strobe),
		.char_code(char_code),
		.last(last)
	);

	fixed_to_decimal_text_checker #(
		.FRAC_BITS(FRAC_BITS),
		.PRECISION_LIMIT(PRECISION_LIMIT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.precision(precision),
		.strobe(strobe),
		.char_code(char_code),
		.last(last),
		.mismatch_count(mismatch_count),
		.chars_pending(chars_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hold start until the item is taken at a rising edge with busy low.
	task automatic send_number(input logic [63:0] v, input int p);
		logic taken;
		@(negedge clk);
		start     <= 1'b1;
		value     <= v;
		precision <= p[4:0];
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
	endtask

	// Drop start for a burst; optionally let the current item finish first.
	task automatic hold_off(input int cycles, input logic after_done);
		@(negedge clk);
		start     <= 1'b0;
		value     <= {$urandom, $urandom};
		precision <= 5'($urandom_range(0, 31));
		if (after_done)
			while (busy) @(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [63:0] signed_q(input logic [63:0] mag, input logic neg);
		return neg ? (~mag + 64'd1) : mag;
	endfunction

	function automatic logic [63:0] random_number();
		logic [63:0] pw;
		logic [31:0] ip;
		logic [31:0] frac;
		int          kind;
		int          k;
		kind = $urandom_range(0, 9);
		frac = $urandom;
		case (kind)
			0, 1: begin
				return {$urandom, $urandom};
			end
			6: begin
				// band edges of the automatic precision
				k  = $urandom_range(0, 6);
				pw = 64'd1;
				repeat (k) pw = pw * 64'd10;
				ip = pw[31:0] - $urandom_range(0, 1);
				frac = {16'hFFFF, frac[15:0]};
			end
			7: begin
				// around saturation
				ip = 32'h7FFF_FFFF - $urandom_range(0, 3) + $urandom_range(0, 6);
			end
			8: begin
				ip   = $urandom_range(0, 2);
				frac = $urandom_range(0, 40);
			end
			9: begin
				ip   = $urandom_range(0, 9);
				frac = {20'hFFFFF, frac[11:0]};
			end
			default: begin
				k  = $urandom_range(0, 6);
				pw = 64'd1;
				repeat (k) pw = pw * 64'd10;
				ip = $urandom % pw[31:0];
			end
		endcase
		return signed_q({ip, frac}, 1'($urandom_range(0, 1)));
	endfunction

	function automatic int random_precision();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 31);
			1:       return -1;
			default: return $urandom_range(0, 10);
		endcase
	endfunction

	task automatic maybe_idle(input int n);
		if (n < RAND_ITEMS - CALM_TAIL && (n / 25) % 3 != 2 && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 10), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int n;
		arst_n    = 1'b0;
		start     = 1'b0;
		value     = '0;
		precision = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// directed: zero, tiny negative, extremes, clamping, band edges, rounding carry
		send_number(64'd0, 0);
		send_number(64'd0, -1);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, -1);
		hold_off(3, 1'b1);
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 0);
		send_number(64'h8000_0000_0000_0000, 10);
		send_number(64'h8000_0000_0000_0000, -8);
		send_number({32'd1, 32'h8000_0000}, 0);
		send_number({32'd1, 32'h8000_0000}, 15);
		send_number(signed_q({32'd9, 32'hFFFF_0000}, 1'b1), -8);
		send_number({32'd10, 32'h0000_0001}, -3);
		send_number({32'd99, 32'hFFFF_FFFF}, -2);
		send_number({32'd999, 32'h1234_5678}, -1);
		send_number(signed_q({32'd9999, 32'hABCD_0000}, 1'b1), -5);
		send_number({32'd99999, 32'hFFFF_FFFF}, -1);
		send_number({32'd100000, 32'hFFFF_FFFF}, -1);
		send_number(64'h7FFF_FFFF_FFFF_0000, 3);
		send_number({32'd0, 32'hFFFF_FFFF}, 1);
		send_number({32'd12345, 32'hAD91_6872}, 3);
		send_number(64'h0123_4567_89AB_CDEF, -16);
		send_number(signed_q({32'd0, 32'h0000_0001}, 1'b1), 10);
		send_number({32'h8000_0000, 32'd0}, 0);
		send_number(64'hFFFF_FFFF_0000_0000, 0);
		hold_off(5, 1'b0);

		for (n = 0; n < RAND_ITEMS; n++) begin
			send_number(random_number(), random_precision());
			maybe_idle(n);
		end

		@(negedge clk);
		start <= 1'b0;
		wait (chars_pending == 0);
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && chars_pending == 0)
			$display("tb_fixed_to_decimal_text_core: done, clean");
		else
			$display("tb_fixed_to_decimal_text_core: done, errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb_fixed_to_decimal_text_core: done, errors");
		$finish;
	end

endmodule
